// ===== sv/cdg_pkg.sv =====
// Shared widths, register codes, reset values and the per-item flag bundle
// for the central-difference gradient block. Depends on nothing.
package cdg_pkg;

   localparam int DEF_MAX_WIDTH = 1024;

   localparam int PIX_W  = 8;
   localparam int GRAD_W = 9;
   localparam int ROW_W  = 16;

   localparam int IMG_W_W = 11;
   localparam int IMG_H_W = 16;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
   localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 16'd1024;

   typedef struct packed {
      logic above;
      logic last_row;
      logic last_col;
      logic interior;
      logic fwd;
   } item_flags_type;

endpackage

// ===== sv/cdg_line_mem.sv =====
// One line store: single write port, single read port, registered read data.
// Read returns the old contents on a same-address write. Uses no package.
module cdg_line_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/cdg_ctrl.sv =====
// Configuration registers, column and row counters and per-item flags.
// Depends on cdg_pkg.
module cdg_ctrl #(
   parameter int MAX_WIDTH = cdg_pkg::DEF_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [cdg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cdg_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           accept,
   output logic [COL_W-1:0]               col,
   output logic [COL_W-1:0]               next_col,
   output logic [cdg_pkg::ROW_W-1:0]      row,
   output cdg_pkg::item_flags_type        flags
);
   import cdg_pkg::*;

   localparam int EW = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

   logic [IMG_W_W-1:0] width_ff, width_in;
   logic [IMG_H_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   logic [EW-1:0]    w_ext, eff_w, col_inc;
   logic [ROW_W:0]   eff_h, row_inc;
   logic             last_col, last_row;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[IMG_H_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_ext = EW'(width_ff);
      if (w_ext == '0) begin
         eff_w = EW'(1);
      end else if (w_ext > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = w_ext;
      end
      eff_h    = (height_ff == '0) ? (ROW_W+1)'(1) : {1'b0, height_ff};
      col_inc  = EW'(col_ff) + EW'(1);
      row_inc  = {1'b0, row_ff} + (ROW_W+1)'(1);
      last_col = (col_inc >= eff_w);
      last_row = (row_inc >= eff_h);
      next_col = last_col ? '0 : col_inc[COL_W-1:0];

      flags.above    = (row_ff != '0);
      flags.last_row = last_row;
      flags.last_col = last_col;
      flags.interior = (col_ff != '0) && !last_col && (row_ff >= ROW_W'(2)) &&
                       ({1'b0, row_ff} < eff_h);
      flags.fwd      = (next_col == col_ff);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = next_col;
         if (last_col) begin
            row_in = last_row ? '0 : row_inc[ROW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign col = col_ff;
   assign row = row_ff;

endmodule

// ===== sv/cdg_grad.sv =====
// Item stage after the line-store reads: gradient arithmetic, result
// sequencing (zero, one or two results per item) and the output register.
// Depends on cdg_pkg.
module cdg_grad #(
   parameter int COL_W = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   output logic                            take_ready,
   input  logic [cdg_pkg::PIX_W-1:0]       pixel,
   input  logic [COL_W-1:0]                col,
   input  logic [cdg_pkg::ROW_W-1:0]       row,
   input  cdg_pkg::item_flags_type         flags,
   input  logic [cdg_pkg::PIX_W-1:0]       prev_rdata,
   input  logic [cdg_pkg::PIX_W-1:0]       older_rdata,
   output logic [cdg_pkg::PIX_W-1:0]       cur_prev,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [cdg_pkg::GRAD_W-1:0] rsp_grad_x_halves,
   output logic signed [cdg_pkg::GRAD_W-1:0] rsp_grad_y_halves,
   output logic [COL_W-1:0]                rsp_out_col,
   output logic [cdg_pkg::ROW_W-1:0]       rsp_out_row,
   output logic                            rsp_frame_end
);
   import cdg_pkg::*;

   logic                s1_v_ff, s1_v_in;
   logic                s1_sel_ff, s1_sel_in;
   item_flags_type      s1_f_ff;
   logic [PIX_W-1:0]    s1_px_ff, s1_left_ff, left_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic [ROW_W-1:0]    s1_row_ff;

   logic                out_v_ff, out_v_in;
   logic [GRAD_W-1:0]   out_gx_ff, out_gy_ff;
   logic [COL_W-1:0]    out_col_ff;
   logic [ROW_W-1:0]    out_row_ff;
   logic                out_fe_ff;

   logic                out_free, above_pend, has_res, emit, final_emit, s1_done;
   logic [GRAD_W-1:0]   gx, gy, res_gx, res_gy;
   logic [ROW_W-1:0]    res_row;
   logic                res_fe;

   always_comb begin
      cur_prev   = s1_f_ff.fwd ? s1_px_ff : prev_rdata;
      out_free   = !out_v_ff || rsp_ready;
      above_pend = s1_f_ff.above && !s1_sel_ff;
      has_res    = s1_f_ff.above || s1_f_ff.last_row;
      emit       = s1_v_ff && has_res && out_free;
      final_emit = emit && !(above_pend && s1_f_ff.last_row);
      s1_done    = s1_v_ff && (!has_res || final_emit);
      take_ready = !s1_v_ff || s1_done;

      gx = s1_f_ff.interior ? ({1'b0, cur_prev} - {1'b0, s1_left_ff}) : '0;
      gy = s1_f_ff.interior ? ({1'b0, s1_px_ff} - {1'b0, older_rdata}) : '0;

      if (above_pend) begin
         res_gx  = gx;
         res_gy  = gy;
         res_row = s1_row_ff - ROW_W'(1);
         res_fe  = 1'b0;
      end else begin
         res_gx  = '0;
         res_gy  = '0;
         res_row = s1_row_ff;
         res_fe  = s1_f_ff.last_col;
      end

      s1_v_in   = accept ? 1'b1 : (s1_done ? 1'b0 : s1_v_ff);
      s1_sel_in = accept ? 1'b0 : (emit ? 1'b1 : s1_sel_ff);
      out_v_in  = out_free ? emit : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s1_sel_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         s1_v_ff   <= s1_v_in;
         s1_sel_ff <= s1_sel_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_f_ff    <= flags;
         s1_px_ff   <= pixel;
         s1_col_ff  <= col;
         s1_row_ff  <= row;
         s1_left_ff <= left_ff;
         left_ff    <= cur_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_gx_ff  <= res_gx;
         out_gy_ff  <= res_gy;
         out_col_ff <= s1_col_ff;
         out_row_ff <= res_row;
         out_fe_ff  <= res_fe;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_grad_x_halves = out_gx_ff;
   assign rsp_grad_y_halves = out_gy_ff;
   assign rsp_out_col       = out_col_ff;
   assign rsp_out_row       = out_row_ff;
   assign rsp_frame_end     = out_fe_ff;

endmodule

// ===== sv/central_difference_gradient.sv =====
// Top level of the streaming central-difference gradient: counters, two
// line stores and the gradient/output stage. Depends on cdg_pkg, cdg_ctrl,
// cdg_line_mem and cdg_grad.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   req_pixel
//   rsp      out  rsp_valid/rsp_ready   grad_x/y_halves, out_col, out_row, frame_end
//   csr      in   csr_we                csr_addr, csr_wdata
//
// One pixel per cycle while req_ready is high. Results pass s1 and rsp registers.
// Last-row pixels with a row above give two results and hold s1 until both go out.
// Each line store has one read and one write port, used once per item.
// Reset clears counters and control only; line stores hold no reset value.
// An output stall holds the stage behind it and drops req_ready.
module central_difference_gradient #(
   parameter int MAX_WIDTH = cdg_pkg::DEF_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cdg_pkg::PIX_W-1:0]           req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cdg_pkg::GRAD_W-1:0]   rsp_grad_x_halves,
   output logic signed [cdg_pkg::GRAD_W-1:0]   rsp_grad_y_halves,
   output logic [$clog2(MAX_WIDTH)-1:0]        rsp_out_col,
   output logic [cdg_pkg::ROW_W-1:0]           rsp_out_row,
   output logic                                rsp_frame_end,
   input  logic                                csr_we,
   input  logic [cdg_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [cdg_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cdg_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic                accept;
   logic [COL_W-1:0]    col, next_col;
   logic [ROW_W-1:0]    row;
   item_flags_type      flags;
   logic [PIX_W-1:0]    prev_rdata, older_rdata, cur_prev;

   assign accept = req_valid && req_ready;

   cdg_ctrl #(
      .MAX_WIDTH(MAX_WIDTH),
      .COL_W    (COL_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata),
      .accept   (accept),
      .col      (col),
      .next_col (next_col),
      .row      (row),
      .flags    (flags)
   );

   cdg_line_mem #(
      .DEPTH (MAX_WIDTH),
      .ADDR_W(COL_W),
      .DATA_W(PIX_W)
   ) u_prev_mem (
      .clock(clock),
      .we   (accept),
      .waddr(col),
      .wdata(req_pixel),
      .re   (accept),
      .raddr(next_col),
      .rdata(prev_rdata)
   );

   cdg_line_mem #(
      .DEPTH (MAX_WIDTH),
      .ADDR_W(COL_W),
      .DATA_W(PIX_W)
   ) u_older_mem (
      .clock(clock),
      .we   (accept),
      .waddr(col),
      .wdata(cur_prev),
      .re   (accept),
      .raddr(col),
      .rdata(older_rdata)
   );

   cdg_grad #(
      .COL_W(COL_W)
   ) u_grad (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .take_ready       (req_ready),
      .pixel            (req_pixel),
      .col              (col),
      .row              (row),
      .flags            (flags),
      .prev_rdata       (prev_rdata),
      .older_rdata      (older_rdata),
      .cur_prev         (cur_prev),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_grad_x_halves(rsp_grad_x_halves),
      .rsp_grad_y_halves(rsp_grad_y_halves),
      .rsp_out_col      (rsp_out_col),
      .rsp_out_row      (rsp_out_row),
      .rsp_frame_end    (rsp_frame_end)
   );

`ifndef SYNTHESIS
   a_frame_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_grad_x_halves == '0 && rsp_grad_y_halves == '0)
      else $error("frame end item carries a nonzero gradient");

   a_grad_not_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_grad_x_halves != '0 || rsp_grad_y_halves != '0) |->
         rsp_out_row != '0 && rsp_out_col != '0)
      else $error("nonzero gradient on a border item");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> col < MAX_WIDTH && next_col < MAX_WIDTH)
      else $error("column counter beyond line store depth");
`endif

endmodule
